/* src/bdq_pkg.sv */
// Shared types, constants and ring-index helpers for the bounded deque with search.
package bdq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 7;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_BACK  = 2'd1,
        ACT_POP_BACK   = 2'd2,
        ACT_SEARCH     = 2'd3
    } bdq_action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } bdq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } bdq_state_t;

    typedef struct packed {
        bdq_action_t         action;
        logic signed [VALUE_W-1:0] value;
    } bdq_req_t;

    typedef struct packed {
        bdq_status_t         status;
        logic                found;
        logic [COUNT_W-1:0]  count;
    } bdq_rsp_t;

    typedef struct packed {
        logic  we;
        ptr_t  waddr;
        word_t wdata;
        logic  re;
        ptr_t  raddr;
    } bdq_mem_req_t;

    function automatic ptr_t ring_add(input ptr_t base, input ptr_t off);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (PTR_W+1)'(DEPTH))
        begin
            sum = sum - (PTR_W+1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic ptr_t ring_dec(input ptr_t p);
        ptr_t r;
        if (p == '0)
        begin
            r = PTR_W'(DEPTH - 1);
        end
        else
        begin
            r = p - PTR_W'(1);
        end
        return r;
    endfunction

endpackage

/* src/bounded_deque_with_search_top.sv */
// Top level of the bounded deque with search: sequencer, entry store and output register.
//
//   channel  valid      stall      word
//   input    req_valid  req_stall  req (action, value)
//   output   rsp_valid  rsp_stall  rsp (status, found, count)
//
// Push and remove: the result word is registered in the sequencer, then moves to the output register.
// Search: the scan reads at most count entries, one store read per cycle
//   on the single read port; an early hit ends the scan.
// The next input word is accepted in the cycle after the previous result moves to the output register.
// Reset clears pointers, count and control; the entry store needs no clearing pass.
// A stalled output holds its word while the next input word is processed.
module bounded_deque_with_search_top
    import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  bdq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output bdq_rsp_t rsp
);

    bdq_mem_req_t mem_req;
    word_t        rdata;
    logic         res_valid;
    logic         res_take;
    bdq_rsp_t     res;
    logic         out_valid_reg, out_valid_next;
    bdq_rsp_t     out_reg, out_next;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .mem_req   (mem_req),
        .rdata     (rdata)
    );

    bdq_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    assign res_take = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_take)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

/* src/bdq_ram.sv */
// Entry store: one write port and one read port with registered read data.
module bdq_ram
    import bdq_pkg::*;
(
    input  logic         clk,
    input  bdq_mem_req_t mem_req,
    output word_t        rdata
);

    word_t mem [DEPTH];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rdata_reg <= mem[mem_req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/bdq_ctrl.sv */
// Sequencer: pointer and count update, store access and search scan.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  bdq_req_t     req,
    output logic         req_stall,
    output logic         res_valid,
    input  logic         res_take,
    output bdq_rsp_t     res,
    output bdq_mem_req_t mem_req,
    input  word_t        rdata
);

    bdq_state_t state_reg, state_next;
    ptr_t       front_reg, front_next;
    cnt_t       count_reg, count_next;
    cnt_t       idx_reg, idx_next;
    word_t      key_reg, key_next;
    bdq_rsp_t   res_reg, res_next;
    word_t      key_in;

    assign key_in = DATA_WIDTH'(req.value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        res_next      = res_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = front_reg;
        mem_req.wdata = key_in;
        mem_req.re    = 1'b0;
        mem_req.raddr = front_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next.status = ST_DONE;
                    res_next.found  = 1'b0;
                    state_next      = S_EMIT;
                    unique case (req.action)
                        ACT_PUSH_FRONT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                front_next    = ring_dec(front_reg);
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ring_dec(front_reg);
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = ring_add(front_reg, count_reg[PTR_W-1:0]);
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        ACT_SEARCH:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_req.re = 1'b1;
                                idx_next   = CNT_W'(1);
                                key_next   = key_in;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_DONE;
                        end
                    endcase
                    res_next.count = COUNT_W'(count_next);
                end
            end
            S_SCAN:
            begin
                if (rdata == key_reg)
                begin
                    res_next.found = 1'b1;
                    state_next     = S_EMIT;
                end
                else if (idx_reg == count_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ring_add(front_reg, idx_reg[PTR_W-1:0]);
                    idx_next      = idx_reg + CNT_W'(1);
                end
            end
            S_EMIT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

endmodule
